### hdl/sswsynth_pkg.sv
// Shared constants and build-time helpers for the sine/square waveform synthesizer.
// Holds register index codes, fixed-point constants and the quarter-wave sine series.
// No dependencies.
`default_nettype none

package sswsynth_pkg;

  // register index codes, taken from paddr[2]
  localparam logic REG_WAVE_MODE      = 1'b0;
  localparam logic REG_HARMONIC_TERMS = 1'b1;

  // pi in unsigned Q30 and 4/pi in unsigned Q1.16
  localparam logic [63:0] PI_Q30           = 64'd3373259426;
  localparam logic [63:0] FOUR_OVER_PI_Q16 = 64'd83443;

  // fixed widths of the term datapath
  localparam int SAMPLE_W = 16;  // Q1.15 table entry
  localparam int RECIP_W  = 17;  // round(65536 / k)
  localparam int ACC_W    = 35;  // signed sum of sample * reciprocal
  localparam int LO_W     = 17;  // low split of the accumulator
  localparam int OP_A_W   = 18;  // signed multiplier operand

  // Q1.15 magnitude of sin(x), x in Q30 within 0..pi/2; eight-term series,
  // every product truncated
  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] rnd;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 0;
    for (int n = 0; n < 8; n++) begin
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
      term = ((term * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
    end
    if (sum < 0) begin
      sum = 0;
    end
    rnd = (64'(sum) + 64'd16384) >> 15;
    return (rnd > 64'd32767) ? 16'd32767 : rnd[15:0];
  endfunction

endpackage

`default_nettype wire

### hdl/sine_square_waveform_synth.sv
// Sine / odd-harmonic square waveform synthesizer, top level.
// Depends on sswsynth_pkg (constants, quarter-wave series); holds the sine ROM,
// the shared multiplier, the accumulator, the sequencer and the APB registers.
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+---------------------------------
//  sample in | phase_index                              | transfer when start && !busy
//  result    | dac_code, clipped                        | one-cycle strobe on done
//  config    | psel penable pwrite paddr pwdata prdata  | APB, write when psel&penable&
//            | pready                                   | pwrite&pready; pready tied high
//
// Flow: in square mode T terms, T being the clamped harmonic count, go through the
// shared multiplier one term per cycle, and the final scaling needs two more passes
// through it plus one wide add. Sine mode uses one table read and one multiply.
// busy stays high from the start transfer until done is shown and is low in the cycle
// in which done is shown; a new start is taken in that same cycle.
// Reset (rst, synchronous) drops any item in flight and loads wave_mode = 0,
// harmonic_terms = 10. The sine ROM is constant and needs no fill.
// The result side cannot stall: done lasts exactly one cycle.
`default_nettype none

module sine_square_waveform_synth
  import sswsynth_pkg::*;
#(
  parameter int PERIOD_STEPS = 1024,
  parameter int MAX_TERMS    = 50,
  parameter int DAC_BITS     = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // sample command
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [$clog2(PERIOD_STEPS)-1:0]   phase_index,
  // result
  output logic                                   done,
  output logic [DAC_BITS-1:0]                    dac_code,
  output logic                                   clipped,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int PB      = $clog2(PERIOD_STEPS);
  localparam int QUARTER = PERIOD_STEPS / 4;
  localparam int NW      = $clog2(MAX_TERMS + 1);
  localparam int RK_IW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int RK_N    = 2 ** RK_IW;
  localparam int BW      = DAC_BITS + 16;            // scale constant width
  localparam int PW      = OP_A_W + BW + 1;          // product width
  localparam int TW      = DAC_BITS + 51;            // final scaled sum width
  localparam int CWD     = DAC_BITS + 5;             // code before saturation
  localparam int SCALE_SHIFT = 47;
  localparam int SINE_SHIFT  = 15;

  localparam logic [BW-1:0] DAC_MID = BW'((64'd1 << (DAC_BITS - 1)) - 64'd1);
  localparam logic [BW-1:0] SCALE   = BW'(FOUR_OVER_PI_Q16 * 64'(DAC_MID));
  localparam logic [DAC_BITS-1:0] DAC_MAX = {DAC_BITS{1'b1}};

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_HI    = 3'd3;
  localparam logic [2:0] S_LO    = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Build one full-period table entry from the quarter-wave series.
  function automatic logic [15:0] sine_entry(input int j);
    int          q;
    int          r;
    int          jj;
    logic [63:0] x;
    logic [15:0] mag;
    q   = j / QUARTER;
    r   = j % QUARTER;
    jj  = ((q % 2) == 1) ? (QUARTER - r) : r;
    x   = (64'd2 * PI_Q30 * 64'(jj) + 64'(PERIOD_STEPS / 2)) / 64'(PERIOD_STEPS);
    mag = quarter_sine(x);
    return ((q / 2) % 2 == 1) ? 16'(17'h10000 - {1'b0, mag}) : mag;
  endfunction

  // ---------------------------------------------------------------------------
  // Constant tables: sine ROM and per-harmonic reciprocals
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sine_rom [PERIOD_STEPS];
  logic [RECIP_W-1:0]  rk_rom   [RK_N];

  for (genvar g = 0; g < PERIOD_STEPS; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  for (genvar g = 0; g < RK_N; g++) begin : g_recip
    localparam int K = 2 * g + 1;
    localparam logic [RECIP_W-1:0] RK = RECIP_W'((131072 + K) / (2 * K));
    assign rk_rom[g] = RK;
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       wave_mode;
  logic [5:0] harmonic_terms;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode      <= 1'b0;
      harmonic_terms <= 6'd10;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WAVE_MODE:      wave_mode      <= pwdata[0];
        REG_HARMONIC_TERMS: harmonic_terms <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WAVE_MODE:      prdata = {31'd0, wave_mode};
      REG_HARMONIC_TERMS: prdata = {26'd0, harmonic_terms};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------------
  logic [2:0]              state;
  logic                    mode_q;     // wave mode held for the item in flight
  logic [NW-1:0]           term_cnt;   // terms to sum (1 in sine mode)
  logic [NW-1:0]           n;          // terms issued so far
  logic [PB-1:0]           idx;        // (i * k) mod period, advanced by 2i
  logic [PB-1:0]           step;
  // term pipeline: address -> table read -> product -> accumulate
  logic                    v0;
  logic                    v1;
  logic                    v2;
  logic [PB-1:0]           rd_addr;
  logic [BW-1:0]           rk0;
  logic [BW-1:0]           rk1;
  logic [SAMPLE_W-1:0]     rom_q;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [TW-1:0]    total;
  // shared multiplier operands
  logic signed [OP_A_W-1:0] mul_a;
  logic [BW-1:0]            mul_b;
  // output stage
  logic signed [CWD-1:0]   code_wide;
  logic [NW-1:0]           t_clamped;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (int'(harmonic_terms) > MAX_TERMS) begin
      t_clamped = NW'(MAX_TERMS);
    end else begin
      t_clamped = NW'(harmonic_terms);
    end
  end

  // one multiplier: term products, then the two halves of acc * scale
  always_comb begin
    case (state)
      S_HI: begin
        mul_a = acc[ACC_W-1:LO_W];
        mul_b = SCALE;
      end
      S_LO: begin
        mul_a = {1'b0, acc[LO_W-1:0]};
        mul_b = SCALE;
      end
      default: begin
        mul_a = {{(OP_A_W - SAMPLE_W){rom_q[SAMPLE_W-1]}}, rom_q};
        mul_b = rk1;
      end
    endcase
  end

  // the shifted sums are signed: sign-extend them into the code width
  always_comb begin
    if (mode_q) begin
      code_wide = CWD'($signed(total[TW-1:SCALE_SHIFT])) + CWD'(signed'({1'b0, DAC_MID}));
    end else begin
      code_wide = CWD'($signed(acc[ACC_W-1:SINE_SHIFT])) + CWD'(signed'({1'b0, DAC_MID}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= v0;
      v2   <= v1;
      v0   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (n == term_cnt) begin
            state <= S_DRAIN;
          end else begin
            v0 <= 1'b1;
            if (n + NW'(1) == term_cnt) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // wait until the last term has reached the accumulator
          if (!v0 && !v1 && !v2) begin
            state <= mode_q ? S_HI : S_OUT;
          end
        end
        S_HI:  state <= S_LO;
        S_LO:  state <= S_SUM;
        S_SUM: state <= S_OUT;
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    rom_q <= sine_rom[rd_addr];
    rk1   <= rk0;
    prod  <= $signed(mul_a) * $signed({1'b0, mul_b});
    if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          mode_q   <= wave_mode;
          term_cnt <= wave_mode ? t_clamped : NW'(1);
          n        <= '0;
          idx      <= phase_index;
          step     <= {phase_index[PB-2:0], 1'b0};
          acc      <= '0;
        end
      end
      S_ISSUE: begin
        if (n != term_cnt) begin
          rd_addr <= idx;
          rk0     <= mode_q ? BW'(rk_rom[n[RK_IW-1:0]]) : DAC_MID;
          idx     <= idx + step;
          n       <= n + NW'(1);
        end
      end
      S_LO:  total <= TW'(prod) <<< LO_W;
      S_SUM: total <= total + TW'(prod);
      S_OUT: begin
        // saturate the Gibbs overshoot into the converter range
        if (code_wide < 0) begin
          dac_code <= '0;
          clipped  <= 1'b1;
        end else if (code_wide > CWD'(signed'({1'b0, DAC_MAX}))) begin
          dac_code <= DAC_MAX;
          clipped  <= 1'b1;
        end else begin
          dac_code <= code_wide[DAC_BITS-1:0];
          clipped  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted sample did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still busy");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_HI) |-> (!v0 && !v1 && !v2))
    else $error("final scaling started with terms still in flight");

  a_sine_noclip: assert property (@(posedge clk) disable iff (rst)
    (done && !mode_q) |-> !clipped)
    else $error("sine mode result was saturated");

endmodule

`default_nettype wire
